### hw/rtl/u8s_pkg.sv
// Shared types, constants and the sequence decision function of the UTF-8 span decoder.
package u8s_pkg;

  localparam logic [7:0]  LEAD_MIN2   = 8'hC2;
  localparam logic [7:0]  LEAD_MAX4   = 8'hF4;
  localparam logic [7:0]  CONT_MASK   = 8'hC0;
  localparam logic [7:0]  CONT_TAG    = 8'h80;
  localparam logic [20:0] CP_REPLACE  = 21'h00FFFD;
  localparam logic [20:0] CP_SURR_LO  = 21'h00D800;
  localparam logic [20:0] CP_SURR_HI  = 21'h00DFFF;
  localparam logic [20:0] CP_MAX      = 21'h10FFFF;
  localparam logic [20:0] CP_MIN3     = 21'h000800;
  localparam logic [20:0] CP_MIN4     = 21'h010000;
  localparam logic [20:0] CP_BMP_MAX  = 21'h00FFFF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHK,
    ST_DEC,
    ST_FAIL
  } state_t;

  typedef enum logic [1:0] {
    DS_WAIT,
    DS_VALID,
    DS_BAD
  } dec_status_t;

  typedef struct packed {
    dec_status_t status;
    logic [20:0] cp;
    logic [2:0]  len;
  } dec_t;

  function automatic logic is_cont(logic [7:0] b);
    return (b & CONT_MASK) == CONT_TAG;
  endfunction

  // Decides the sequence that starts at position p of the m bytes in b.
  function automatic dec_t decide(logic [3:0][7:0] b, logic [2:0] p, logic [2:0] m,
                                  logic last);
    dec_t        r;
    logic [7:0]  c0;
    logic [7:0]  bk;
    logic [2:0]  need;
    logic [2:0]  idx;
    logic [20:0] v;
    logic        stop;
    r.status = DS_BAD;
    r.cp     = '0;
    r.len    = 3'd1;
    c0       = b[p[1:0]];
    need     = 3'd0;
    v        = '0;
    stop     = 1'b0;
    if (c0 < CONT_TAG) begin
      r.status = DS_VALID;
      r.cp     = {13'd0, c0};
    end else begin
      if ((c0 & 8'hE0) == 8'hC0) begin
        need = 3'd2;
        v    = {16'd0, c0[4:0]};
      end else if ((c0 & 8'hF0) == 8'hE0) begin
        need = 3'd3;
        v    = {17'd0, c0[3:0]};
      end else if ((c0 & 8'hF8) == 8'hF0) begin
        need = 3'd4;
        v    = {18'd0, c0[2:0]};
      end
      if (need == 3'd0) begin
        stop = 1'b1;
      end
      for (int k = 1; k < 4; k++) begin
        if (!stop && 3'(k) < need) begin
          idx = p + 3'(k);
          bk  = b[idx[1:0]];
          if (idx >= m) begin
            stop     = 1'b1;
            r.status = last ? DS_BAD : DS_WAIT;
          end else if (!is_cont(bk)) begin
            stop = 1'b1;
          end else begin
            v = {v[14:0], bk[5:0]};
          end
        end
      end
      if (!stop) begin
        if (need == 3'd2 && c0 < LEAD_MIN2) begin
          r.status = DS_BAD;
        end else if (need == 3'd3 &&
                     (v < CP_MIN3 || (v >= CP_SURR_LO && v <= CP_SURR_HI))) begin
          r.status = DS_BAD;
        end else if (need == 3'd4 && (c0 > LEAD_MAX4 || v < CP_MIN4 || v > CP_MAX)) begin
          r.status = DS_BAD;
        end else begin
          r.status = DS_VALID;
          r.cp     = v;
          r.len    = need;
        end
      end
    end
    return r;
  endfunction

endpackage

### hw/rtl/u8s_in_if.sv
// Input channel interface carrying one text byte per word.
interface u8s_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

### hw/rtl/u8s_out_if.sv
// Result channel interface carrying one decoded span per word.
interface u8s_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic [23:0] byte_offset;
  logic [2:0]  byte_length;
  logic [23:0] unit16_offset;
  logic [1:0]  unit16_length;
  logic        replaced;
  logic        strict_failure;
  logic        final_result;

  modport source (output valid, output code_point, output byte_offset, output byte_length,
                  output unit16_offset, output unit16_length, output replaced,
                  output strict_failure, output final_result, input ready);
  modport sink (input valid, input code_point, input byte_offset, input byte_length,
                input unit16_offset, input unit16_length, input replaced,
                input strict_failure, input final_result, output ready);
endinterface

### hw/rtl/utf8_decoder_with_spans_unit.sv
// Top level of the UTF-8 span decoder: byte intake, sequence decision loop and result register.
//
// Channel  Direction  Word
// in_ch    sink       text_byte, end_of_text
// out_ch   source     one span or the failure word
// cfg_*    write      replacement enable
//
// A byte is taken in the intake state, then each span it completes is decided in turn, and a
// closing decision returns to intake. In abort mode the last byte of a text first runs a
// checking pass, one sequence per cycle, before decoding. A byte of an aborted text is only
// taken at intake, and the last one then leads to the failure word. Decisions and the
// failure word stall while the result register is full and not taken. Reset is synchronous
// and clears all control state.
module utf8_decoder_with_spans_unit #(
  parameter int OFFSET_BITS = 24
) (
  input  logic      clk,
  input  logic      rst_n,
  u8s_in_if.sink    in_ch,
  u8s_out_if.source out_ch,
  input  logic      cfg_we,
  input  logic      cfg_wdata
);
  import u8s_pkg::*;

  state_t                 state_r, state_nxt;
  logic [3:0][7:0]        buf_r, buf_nxt;
  logic [2:0]             m_r, m_nxt;
  logic [2:0]             p_r, p_nxt;
  logic                   eot_r, eot_nxt;
  logic                   aborted_r, aborted_nxt;
  logic                   replace_r;
  logic [OFFSET_BITS-1:0] bpos_r, bpos_nxt;
  logic [OFFSET_BITS-1:0] upos_r, upos_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [20:0]            cp_r, cp_nxt;
  logic [23:0]            boff_r, boff_nxt;
  logic [2:0]             blen_r, blen_nxt;
  logic [23:0]            uoff_r, uoff_nxt;
  logic [1:0]             ulen_r, ulen_nxt;
  logic                   rep_r, rep_nxt;
  logic                   fail_r, fail_nxt;
  logic                   fin_r, fin_nxt;

  dec_t                   dr;
  logic                   out_free;
  logic                   emit;
  logic [20:0]            e_cp;
  logic [2:0]             e_len;
  logic                   e_rep;
  logic [1:0]             e_ulen;
  logic [OFFSET_BITS+23:0] bpos_ext;
  logic [OFFSET_BITS+23:0] upos_ext;

  assign dr        = decide(buf_r, p_r, m_r, eot_r);
  assign out_free  = !out_valid_r || out_ch.ready;
  assign e_ulen    = (e_cp > CP_BMP_MAX) ? 2'd2 : 2'd1;
  assign bpos_ext  = {24'd0, bpos_r};
  assign upos_ext  = {24'd0, upos_r};

  assign in_ch.ready          = (state_r == ST_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.code_point    = cp_r;
  assign out_ch.byte_offset   = boff_r;
  assign out_ch.byte_length   = blen_r;
  assign out_ch.unit16_offset = uoff_r;
  assign out_ch.unit16_length = ulen_r;
  assign out_ch.replaced      = rep_r;
  assign out_ch.strict_failure = fail_r;
  assign out_ch.final_result  = fin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      m_r         <= '0;
      p_r         <= '0;
      eot_r       <= 1'b0;
      aborted_r   <= 1'b0;
      replace_r   <= 1'b1;
      bpos_r      <= '0;
      upos_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      m_r         <= m_nxt;
      p_r         <= p_nxt;
      eot_r       <= eot_nxt;
      aborted_r   <= aborted_nxt;
      bpos_r      <= bpos_nxt;
      upos_r      <= upos_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        replace_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    buf_r  <= buf_nxt;
    cp_r   <= cp_nxt;
    boff_r <= boff_nxt;
    blen_r <= blen_nxt;
    uoff_r <= uoff_nxt;
    ulen_r <= ulen_nxt;
    rep_r  <= rep_nxt;
    fail_r <= fail_nxt;
    fin_r  <= fin_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    buf_nxt       = buf_r;
    m_nxt         = m_r;
    p_nxt         = p_r;
    eot_nxt       = eot_r;
    aborted_nxt   = aborted_r;
    bpos_nxt      = bpos_r;
    upos_nxt      = upos_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    cp_nxt        = cp_r;
    boff_nxt      = boff_r;
    blen_nxt      = blen_r;
    uoff_nxt      = uoff_r;
    ulen_nxt      = ulen_r;
    rep_nxt       = rep_r;
    fail_nxt      = fail_r;
    fin_nxt       = fin_r;
    emit          = 1'b0;
    e_cp          = dr.cp;
    e_len         = dr.len;
    e_rep         = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          if (aborted_r) begin
            if (in_ch.end_of_text) begin
              state_nxt = ST_FAIL;
            end
          end else begin
            buf_nxt[m_r[1:0]] = in_ch.text_byte;
            m_nxt             = m_r + 3'd1;
            p_nxt             = '0;
            eot_nxt           = in_ch.end_of_text;
            state_nxt         = (in_ch.end_of_text && !replace_r) ? ST_CHK : ST_DEC;
          end
        end
      end
      ST_CHK: begin
        if (p_r >= m_r) begin
          p_nxt     = '0;
          state_nxt = ST_DEC;
        end else if (dr.status == DS_BAD) begin
          state_nxt = ST_FAIL;
        end else begin
          p_nxt = p_r + dr.len;
        end
      end
      ST_DEC: begin
        if (p_r >= m_r || dr.status == DS_WAIT) begin
          if (eot_r) begin
            m_nxt       = '0;
            bpos_nxt    = '0;
            upos_nxt    = '0;
            aborted_nxt = 1'b0;
          end else begin
            for (int i = 0; i < 3; i++) begin
              buf_nxt[i] = buf_r[2'(p_r + 3'(i))];
            end
            m_nxt = m_r - p_r;
          end
          p_nxt     = '0;
          state_nxt = ST_IDLE;
        end else if (dr.status == DS_VALID) begin
          emit = out_free;
        end else if (replace_r) begin
          e_cp  = CP_REPLACE;
          e_len = 3'd1;
          e_rep = 1'b1;
          emit  = out_free;
        end else if (eot_r) begin
          state_nxt = ST_FAIL;
        end else begin
          aborted_nxt = 1'b1;
          m_nxt       = '0;
          p_nxt       = '0;
          state_nxt   = ST_IDLE;
        end
      end
      ST_FAIL: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          cp_nxt        = '0;
          boff_nxt      = '0;
          blen_nxt      = '0;
          uoff_nxt      = '0;
          ulen_nxt      = '0;
          rep_nxt       = 1'b0;
          fail_nxt      = 1'b1;
          fin_nxt       = 1'b1;
          m_nxt         = '0;
          p_nxt         = '0;
          bpos_nxt      = '0;
          upos_nxt      = '0;
          aborted_nxt   = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (emit) begin
      out_valid_nxt = 1'b1;
      cp_nxt        = e_cp;
      boff_nxt      = bpos_ext[23:0];
      blen_nxt      = e_len;
      uoff_nxt      = upos_ext[23:0];
      ulen_nxt      = e_ulen;
      rep_nxt       = e_rep;
      fail_nxt      = 1'b0;
      fin_nxt       = eot_r && ((p_r + e_len) == m_r);
      p_nxt         = p_r + e_len;
      bpos_nxt      = bpos_r + OFFSET_BITS'(e_len);
      upos_nxt      = upos_r + OFFSET_BITS'(e_ulen);
    end
  end

endmodule
